>>> hdl/assert_macros.svh
// Assertion macros used by the checker in ptst_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on the clock and reset of the enclosing module.
`define CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on the clock and reset of the enclosing module.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ptst_pkg.sv
// Package with sizes, payload types and status codes of the priority task table.
package ptst_pkg;

	localparam int NUM_CLASSES = 9;
	localparam int SLOTS       = 8;

	localparam int CLS_AW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_CLASS = 2'd2,
		ST_BAD_POS   = 2'd3
	} status_t;

	typedef enum logic {
		ACT_REGISTER   = 1'b0,
		ACT_UNREGISTER = 1'b1
	} action_t;

	typedef struct packed {
		action_t     action;
		logic [3:0]  rate_class;
		logic [7:0]  priority_req;
		logic [15:0] task_handle;
		logic [2:0]  position;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [2:0] slot;
		logic [3:0] entries_in_class;
	} rsp_t;

	typedef struct packed {
		logic [15:0] handle;
		logic [7:0]  prio;
	} entry_t;

	typedef entry_t [SLOTS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

endpackage

>>> hdl/ptst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ptst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hdl/priority_sorted_task_table_unit.sv
// Top level of the priority-sorted task table: class rows in RAM, counts in flops.
//
// Requests arrive on req (valid/stall), one per item; each request yields
// exactly one response on rsp (valid/stall). A register request inserts the
// handle after every entry of lower or equal priority in its class list; an
// unregister request removes the entry at a slot and closes the gap.
// A request is accepted together with the read of its class row from the
// row RAM; the row is then modified and written back and the response
// registered, and req_stall holds off the next request until that write-back
// is done, so a new request is not taken while one is in flight.
// While rsp is stalled the finished response holds in its output register;
// a request still being worked on waits for it, and req_stall stays high.
// Reset clears the per-class entry counts and all valid flags; the row RAM
// is not cleared, as only entries below a class's count are ever used.
// An invalid class still gives a response and leaves all state unchanged.
module priority_sorted_task_table_unit import ptst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic             busy_s1;
	req_t             req_s1;
	logic [CNT_W-1:0] cnt_q [NUM_CLASSES];
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             req_acc;
	logic             req_cls_ok;
	logic             complete;
	logic             cls_ok;
	logic [CLS_AW-1:0] cls;
	logic [CNT_W-1:0] n;
	logic [CNT_W-1:0] at;
	logic [SLOTS-1:0] le_mask;
	row_t             row_rd;
	row_t             row_wr;
	logic [ROW_W-1:0] rd_data;
	logic             wr_en;
	rsp_t             rsp_next;
	logic [CNT_W-1:0] n_next;

	assign req_stall  = busy_s1;
	assign req_acc    = req_valid && !req_stall;
	assign req_cls_ok = {1'b0, req.rate_class} < 5'(NUM_CLASSES);
	assign complete   = busy_s1 && !(rsp_valid_q && rsp_stall);

	assign cls    = req_s1.rate_class[CLS_AW-1:0];
	assign cls_ok = {1'b0, req_s1.rate_class} < 5'(NUM_CLASSES);
	assign n      = cls_ok ? cnt_q[cls] : '0;
	assign row_rd = row_t'(rd_data);

	ptst_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_CLASSES)
	) u_row_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cls),
		.wr_data (ROW_W'(row_wr)),
		.rd_en   (req_acc && req_cls_ok),
		.rd_addr (req.rate_class[CLS_AW-1:0]),
		.rd_data (rd_data)
	);

	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			le_mask[k] = (32'(k) < 32'(n)) && (row_rd[k].prio <= req_s1.priority_req);
		end
		at = CNT_W'($countones(le_mask));
	end

	always_comb begin
		row_wr   = row_rd;
		n_next   = n;
		wr_en    = 1'b0;
		rsp_next = '{status: ST_BAD_CLASS, slot: 3'd0, entries_in_class: 4'd0};
		if (cls_ok) begin
			unique case (req_s1.action)
				ACT_REGISTER: begin
					if (32'(n) >= 32'(SLOTS)) begin
						rsp_next = '{status: ST_FULL, slot: 3'd0, entries_in_class: 4'(n)};
					end else begin
						for (int k = 0; k < SLOTS; k++) begin
							if (32'(k) == 32'(at)) begin
								row_wr[k].handle = req_s1.task_handle;
								row_wr[k].prio   = req_s1.priority_req;
							end else if (32'(k) > 32'(at)) begin
								row_wr[k] = row_rd[(k > 0) ? k - 1 : 0];
							end
						end
						n_next   = n + 1'b1;
						wr_en    = complete;
						rsp_next = '{status: ST_OK, slot: 3'(at),
							entries_in_class: 4'(n_next)};
					end
				end
				ACT_UNREGISTER: begin
					if (32'(req_s1.position) >= 32'(n)) begin
						rsp_next = '{status: ST_BAD_POS, slot: req_s1.position,
							entries_in_class: 4'(n)};
					end else begin
						for (int k = 0; k < SLOTS; k++) begin
							if (32'(k) + 1 == 32'(n)) begin
								row_wr[k] = '0;
							end else if (32'(k) >= 32'(req_s1.position)
									&& 32'(k) + 1 < 32'(n)) begin
								row_wr[k] = row_rd[(k < SLOTS - 1) ? k + 1 : k];
							end
						end
						n_next   = n - 1'b1;
						wr_en    = complete;
						rsp_next = '{status: ST_OK, slot: req_s1.position,
							entries_in_class: 4'(n_next)};
					end
				end
				default: begin
					rsp_next = '{status: ST_BAD_CLASS, slot: 3'd0, entries_in_class: 4'd0};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				cnt_q[c] <= '0;
			end
		end else begin
			if (req_acc) begin
				busy_s1 <= 1'b1;
			end else if (complete) begin
				busy_s1 <= 1'b0;
			end
			if (complete) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (wr_en) begin
				cnt_q[cls] <= n_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_s1 <= req;
		end
		if (complete) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> hdl/ptst_checker.sv
// Port checker for the priority task table, bound to the top level.
`include "assert_macros.svh"

module ptst_checker import ptst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	`CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid,
		"response dropped while stalled")
	`CHK_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall,
		"second request taken in flight")
	`CHK_NOW(a_bad_class_empty, rsp_valid && rsp.status == ST_BAD_CLASS,
		rsp.slot == 3'd0 && rsp.entries_in_class == 4'd0,
		"invalid class response not empty")
	`CHK_NOW(a_count_range, rsp_valid, 32'(rsp.entries_in_class) <= 32'(SLOTS),
		"entry count beyond list size")

endmodule

bind priority_sorted_task_table_unit ptst_checker u_ptst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

>>> tb/tb_priority_sorted_task_table_unit.sv
// Testbench for the priority-sorted task table: random and directed requests checked against a mirror of the class lists.
module tb_priority_sorted_task_table_unit;
	import ptst_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_REQS = 650;

	class task_list_mirror;
		logic [7:0]  prio_of   [NUM_CLASSES][SLOTS];
		logic [15:0] handle_of [NUM_CLASSES][SLOTS];
		int unsigned fill      [NUM_CLASSES];
		rsp_t        pending_rsp [$];
		int          errors;

		function new();
			foreach (prio_of[c, s]) begin
				prio_of[c][s]   = '0;
				handle_of[c][s] = '0;
			end
			foreach (fill[c])
				fill[c] = 0;
			errors = 0;
		endfunction

		function int unsigned entries(int unsigned cls);
			return fill[cls];
		endfunction

		function int unsigned outstanding();
			return pending_rsp.size();
		endfunction

		function void note_request(req_t r);
			rsp_t        e;
			int unsigned cls;
			int unsigned n;
			int unsigned at;
			cls                = r.rate_class;
			e.status           = ST_OK;
			e.slot             = '0;
			e.entries_in_class = '0;
			if (cls >= NUM_CLASSES) begin
				e.status = ST_BAD_CLASS;
			end else if (r.action == ACT_REGISTER) begin
				n = fill[cls];
				if (n >= SLOTS) begin
					e.status           = ST_FULL;
					e.entries_in_class = 4'(n);
				end else begin
					at = 0;
					while (at < n && prio_of[cls][at] <= r.priority_req)
						at++;
					for (int k = n; k > at; k--) begin
						prio_of[cls][k]   = prio_of[cls][k-1];
						handle_of[cls][k] = handle_of[cls][k-1];
					end
					prio_of[cls][at]   = r.priority_req;
					handle_of[cls][at] = r.task_handle;
					fill[cls]          = n + 1;
					e.slot             = 3'(at);
					e.entries_in_class = 4'(n + 1);
				end
			end else begin
				n = fill[cls];
				if (r.position >= n) begin
					e.status           = ST_BAD_POS;
					e.slot             = r.position;
					e.entries_in_class = 4'(n);
				end else begin
					for (int k = r.position; k + 1 < n; k++) begin
						prio_of[cls][k]   = prio_of[cls][k+1];
						handle_of[cls][k] = handle_of[cls][k+1];
					end
					prio_of[cls][n-1]   = '0;
					handle_of[cls][n-1] = '0;
					fill[cls]           = n - 1;
					e.slot              = r.position;
					e.entries_in_class  = 4'(n - 1);
				end
			end
			pending_rsp.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (pending_rsp.size() == 0) begin
				$error("unexpected response: status %0d slot %0d entries_in_class %0d",
					got.status, got.slot, got.entries_in_class);
				errors++;
				return;
			end
			e = pending_rsp.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
			if (got.slot !== e.slot) begin
				$error("slot: expected %0d, got %0d", e.slot, got.slot);
				errors++;
			end
			if (got.entries_in_class !== e.entries_in_class) begin
				$error("entries_in_class: expected %0d, got %0d",
					e.entries_in_class, got.entries_in_class);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	task_list_mirror mirror = new();
	int unsigned     cycle_cnt = 0;

	priority_sorted_task_table_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic req_t make_req(action_t a, int cls, int p, int h, int pos);
		req_t r;
		r.action       = a;
		r.rate_class   = 4'(cls);
		r.priority_req = 8'(p);
		r.task_handle  = 16'(h);
		r.position     = 3'(pos);
		return r;
	endfunction

	function automatic int pick_gap(int idx);
		int r;
		r = $urandom_range(0, 99);
		if ((idx / 60) % 3 == 1)
			return 0;
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic req_t random_request(int idx);
		req_t        r;
		int unsigned cls;
		int unsigned n;
		bit          fill_phase;
		r.action       = action_t'(1'($urandom_range(0, 1)));
		r.rate_class   = 4'($urandom_range(0, 15));
		r.priority_req = 8'($urandom);
		r.task_handle  = 16'($urandom);
		r.position     = 3'($urandom);
		if ($urandom_range(0, 99) < 10)
			return r;
		fill_phase   = ((idx / 90) % 2) == 0;
		cls          = $urandom_range(0, NUM_CLASSES - 1);
		n            = mirror.entries(cls);
		r.rate_class = 4'(cls);
		if (n == 0)
			r.action = ACT_REGISTER;
		else if (n >= SLOTS)
			r.action = ($urandom_range(0, 99) < 80) ? ACT_UNREGISTER : ACT_REGISTER;
		else
			r.action = ($urandom_range(0, 99) < (fill_phase ? 75 : 30)) ?
				ACT_REGISTER : ACT_UNREGISTER;
		if ($urandom_range(0, 99) < 35) begin
			case ($urandom_range(0, 3))
				0: r.priority_req = 8'd0;
				1: r.priority_req = 8'd255;
				2: r.priority_req = 8'd128;
				default: r.priority_req = 8'($urandom_range(60, 63));
			endcase
		end
		if (r.action == ACT_UNREGISTER && n > 0 && $urandom_range(0, 99) < 85)
			r.position = 3'($urandom_range(0, n - 1));
		return r;
	endfunction

	task automatic send_request(input req_t r, input int gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		mirror.note_request(r);
	endtask

	initial begin
		int idx;
		idx = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_req(ACT_UNREGISTER, 0, 0, 16'h1234, 0), pick_gap(idx++));
		send_request(make_req(ACT_REGISTER, 0, 128, 16'h0000, 0), pick_gap(idx++));
		send_request(make_req(ACT_REGISTER, 0, 255, 16'hFFFF, 7), pick_gap(idx++));
		send_request(make_req(ACT_REGISTER, 0, 0, 16'h0001, 0), pick_gap(idx++));
		send_request(make_req(ACT_REGISTER, 0, 128, 16'hAAAA, 5), pick_gap(idx++));
		send_request(make_req(ACT_REGISTER, 0, 128, 16'h5555, 2), pick_gap(idx++));
		send_request(make_req(ACT_REGISTER, 0, 64, 16'h00FF, 0), pick_gap(idx++));
		send_request(make_req(ACT_REGISTER, 0, 200, 16'hFF00, 0), pick_gap(idx++));
		send_request(make_req(ACT_REGISTER, 0, 0, 16'h8000, 0), pick_gap(idx++));
		send_request(make_req(ACT_REGISTER, 0, 7, 16'h7FFF, 0), pick_gap(idx++));
		send_request(make_req(ACT_UNREGISTER, 0, 0, 16'h0000, 7), pick_gap(idx++));
		send_request(make_req(ACT_UNREGISTER, 0, 255, 16'hFFFF, 7), pick_gap(idx++));
		send_request(make_req(ACT_UNREGISTER, 0, 0, 16'h0000, 0), pick_gap(idx++));
		send_request(make_req(ACT_REGISTER, 8, 255, 16'hFFFF, 7), pick_gap(idx++));
		send_request(make_req(ACT_UNREGISTER, 8, 0, 16'h0000, 0), pick_gap(idx++));
		send_request(make_req(ACT_REGISTER, 9, 10, 16'h0042, 0), pick_gap(idx++));
		send_request(make_req(ACT_REGISTER, 15, 255, 16'hFFFF, 7), pick_gap(idx++));
		send_request(make_req(ACT_UNREGISTER, 15, 0, 16'h0000, 7), pick_gap(idx++));
		send_request(make_req(ACT_UNREGISTER, 12, 0, 16'h0000, 3), pick_gap(idx++));
		send_request(make_req(ACT_REGISTER, 8, 0, 16'h8001, 7), pick_gap(idx++));

		for (int i = 0; i < RANDOM_REQS; i++)
			send_request(random_request(i), pick_gap(idx++));
		req_valid <= 1'b0;

		while (mirror.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mirror.errors == 0)
			$display("tb_priority_sorted_task_table_unit: done, clean");
		else
			$display("tb_priority_sorted_task_table_unit: done, errors");
		$finish;
	end

	initial begin
		int stall_run;
		int seen;
		int tick;
		int r;
		int next_hold_at;
		stall_run    = 0;
		seen         = 0;
		tick         = 0;
		next_hold_at = 150;
		forever begin
			@(posedge clk);
			tick++;
			if (arst_n && rsp_valid && !rsp_stall) begin
				mirror.check_response(rsp);
				seen++;
			end
			if (seen == next_hold_at) begin
				stall_run    = 150;
				next_hold_at = (next_hold_at == 150) ? 480 : -1;
			end
			if (stall_run == 0 && (tick / 250) % 3 != 0) begin
				r = $urandom_range(0, 99);
				if (r < 25)
					stall_run = $urandom_range(1, 3);
				else if (r < 29)
					stall_run = $urandom_range(10, 30);
			end
			if (stall_run > 0) begin
				rsp_stall <= 1'b1;
				stall_run--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb_priority_sorted_task_table_unit: done, errors");
		$finish;
	end

endmodule
